// ===== src/sit_pkg.sv =====
package sit_pkg;

	// sign of an orientation test
	typedef logic [1:0] orient_t;

	localparam orient_t ORI_ZERO = 2'd0;
	localparam orient_t ORI_POS  = 2'd1;
	localparam orient_t ORI_NEG  = 2'd2;

endpackage

// ===== src/sit_orient.sv =====
module sit_orient #(
	parameter int DIFF_BITS = 17
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [DIFF_BITS-1:0] ux,
	input  logic signed [DIFF_BITS-1:0] uy,
	input  logic signed [DIFF_BITS-1:0] vx,
	input  logic signed [DIFF_BITS-1:0] vy,
	output sit_pkg::orient_t            ori
);

	localparam int PROD_BITS = 2 * DIFF_BITS;

	logic signed [PROD_BITS-1:0] lhs_s2;
	logic signed [PROD_BITS-1:0] rhs_s2;

	// the two cross terms are compared rather than subtracted
	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s2 <= PROD_BITS'(ux * vy);
			rhs_s2 <= PROD_BITS'(vx * uy);
		end
	end

	always_comb begin
		if (lhs_s2 > rhs_s2)
			ori = sit_pkg::ORI_POS;
		else if (lhs_s2 < rhs_s2)
			ori = sit_pkg::ORI_NEG;
		else
			ori = sit_pkg::ORI_ZERO;
	end

endmodule

// ===== src/segment_intersection_test.sv =====
// Segment intersection test: decides whether two integer line segments A and B
// touch or cross; any negative coordinate of B gives a result of no intersection.
// Input channel s_*: one transaction carries both segments, eight signed
// COORD_BITS wide coordinates in s_tdata. Output channel m_*: one transaction
// per input, bit 0 of m_tdata is the intersects flag.
// Pipeline: stage 1 forms coordinate differences and sorts the endpoints,
// stage 2 holds the eight cross products (one multiplier each) and the
// lexicographic compares, stage 3 compares product pairs, combines the signs
// and holds the result. m_tvalid is the stage 3 valid bit, so a result passes
// the stage 1, stage 2 and stage 3 registers before it is offered;
// throughput is one transaction per cycle while m_tready does not stall.
// Each stage moves when the stage after it is empty or moving, so a stall on
// m_tready backs up through the stages without losing or repeating data, and
// s_tready falls only once all three stages are full.
// Reset clears the stage valid bits; the pipeline is empty afterwards.
module segment_intersection_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*COORD_BITS-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// intersects, then zero padding
	output logic [7:0]              m_tdata
);

	localparam int CB = COORD_BITS;
	localparam int DB = COORD_BITS + 1;

	function automatic logic lex_le(input logic signed [CB-1:0] ax,
	                                input logic signed [CB-1:0] ay,
	                                input logic signed [CB-1:0] bx,
	                                input logic signed [CB-1:0] by);
		logic res;
		if (ax == bx)
			res = (ay <= by);
		else
			res = (ax <= bx);
		return res;
	endfunction

	function automatic logic signed [DB-1:0] diff(input logic signed [CB-1:0] p,
	                                              input logic signed [CB-1:0] q);
		return {p[CB-1], p} - {q[CB-1], q};
	endfunction

	logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

	assign ax0 = s_tdata[0*CB +: CB];
	assign ay0 = s_tdata[1*CB +: CB];
	assign ax1 = s_tdata[2*CB +: CB];
	assign ay1 = s_tdata[3*CB +: CB];
	assign bx0 = s_tdata[4*CB +: CB];
	assign by0 = s_tdata[5*CB +: CB];
	assign bx1 = s_tdata[6*CB +: CB];
	assign by1 = s_tdata[7*CB +: CB];

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	// stage 1: differences, negative check, endpoint ordering
	logic signed [DB-1:0] da_x_s1, da_y_s1, ab0_x_s1, ab0_y_s1, ab1_x_s1, ab1_y_s1;
	logic signed [DB-1:0] db_x_s1, db_y_s1, ba0_x_s1, ba0_y_s1, ba1_x_s1, ba1_y_s1;
	logic                 neg_s1;
	logic signed [CB-1:0] alo_x_s1, alo_y_s1, ahi_x_s1, ahi_y_s1;
	logic signed [CB-1:0] blo_x_s1, blo_y_s1, bhi_x_s1, bhi_y_s1;
	logic                 swap_a, swap_b;

	assign swap_a = lex_le(ax1, ay1, ax0, ay0);
	assign swap_b = lex_le(bx1, by1, bx0, by0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (ready_s1)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			da_x_s1  <= diff(ax1, ax0);
			da_y_s1  <= diff(ay1, ay0);
			ab0_x_s1 <= diff(bx0, ax0);
			ab0_y_s1 <= diff(by0, ay0);
			ab1_x_s1 <= diff(bx1, ax0);
			ab1_y_s1 <= diff(by1, ay0);
			db_x_s1  <= diff(bx1, bx0);
			db_y_s1  <= diff(by1, by0);
			ba0_x_s1 <= diff(ax0, bx0);
			ba0_y_s1 <= diff(ay0, by0);
			ba1_x_s1 <= diff(ax1, bx0);
			ba1_y_s1 <= diff(ay1, by0);
			neg_s1   <= bx0[CB-1] | by0[CB-1] | bx1[CB-1] | by1[CB-1];
			alo_x_s1 <= swap_a ? ax1 : ax0;
			alo_y_s1 <= swap_a ? ay1 : ay0;
			ahi_x_s1 <= swap_a ? ax0 : ax1;
			ahi_y_s1 <= swap_a ? ay0 : ay1;
			blo_x_s1 <= swap_b ? bx1 : bx0;
			blo_y_s1 <= swap_b ? by1 : by0;
			bhi_x_s1 <= swap_b ? bx0 : bx1;
			bhi_y_s1 <= swap_b ? by0 : by1;
		end
	end

	// stage 2: cross products inside the orientation units, range compares here
	logic en_s2;
	logic neg_s2, le_lo_s2, le_hi_s2;

	assign en_s2 = ready_s2 && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (ready_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2   <= neg_s1;
			le_lo_s2 <= lex_le(blo_x_s1, blo_y_s1, ahi_x_s1, ahi_y_s1);
			le_hi_s2 <= lex_le(alo_x_s1, alo_y_s1, bhi_x_s1, bhi_y_s1);
		end
	end

	sit_pkg::orient_t ori_ab0, ori_ab1, ori_ba0, ori_ba1;

	sit_orient #(.DIFF_BITS(DB)) u_ori_ab0 (
		.clk(clk), .en(en_s2),
		.ux(da_x_s1), .uy(da_y_s1), .vx(ab0_x_s1), .vy(ab0_y_s1),
		.ori(ori_ab0)
	);

	sit_orient #(.DIFF_BITS(DB)) u_ori_ab1 (
		.clk(clk), .en(en_s2),
		.ux(da_x_s1), .uy(da_y_s1), .vx(ab1_x_s1), .vy(ab1_y_s1),
		.ori(ori_ab1)
	);

	sit_orient #(.DIFF_BITS(DB)) u_ori_ba0 (
		.clk(clk), .en(en_s2),
		.ux(db_x_s1), .uy(db_y_s1), .vx(ba0_x_s1), .vy(ba0_y_s1),
		.ori(ori_ba0)
	);

	sit_orient #(.DIFF_BITS(DB)) u_ori_ba1 (
		.clk(clk), .en(en_s2),
		.ux(db_x_s1), .uy(db_y_s1), .vx(ba1_x_s1), .vy(ba1_y_s1),
		.ori(ori_ba1)
	);

	// stage 3: combine signs into the answer
	logic zero_ab, zero_ba, nonpos_ab, nonpos_ba, hit;
	logic hit_s3;

	assign zero_ab   = (ori_ab0 == sit_pkg::ORI_ZERO) || (ori_ab1 == sit_pkg::ORI_ZERO);
	assign zero_ba   = (ori_ba0 == sit_pkg::ORI_ZERO) || (ori_ba1 == sit_pkg::ORI_ZERO);
	// product of two signs is non-positive when one is zero or they differ
	assign nonpos_ab = zero_ab || (ori_ab0 != ori_ab1);
	assign nonpos_ba = zero_ba || (ori_ba0 != ori_ba1);

	always_comb begin
		if (neg_s2)
			hit = 1'b0;
		else if (zero_ab && zero_ba)
			hit = le_lo_s2 && le_hi_s2;
		else
			hit = nonpos_ab && nonpos_ba;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (ready_s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2)
			hit_s3 <= hit;
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {7'b0, hit_s3};

endmodule

// ===== sim/segment_intersection_test_tb.sv =====
`timescale 1ns / 1ps

module segment_intersection_test_tb;

	localparam int COORD_BITS      = 16;
	localparam int N_PROBES        = 22;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int BACKLOG_ITEMS   = 40;
	localparam int HOLD_CYCLES     = 200;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 3000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// declared msb first, so a_start_x lands in the lowest bits of s_tdata
	typedef struct packed {
		coord_t b_end_y;
		coord_t b_end_x;
		coord_t b_start_y;
		coord_t b_start_x;
		coord_t a_end_y;
		coord_t a_end_x;
		coord_t a_start_y;
		coord_t a_start_x;
	} seg_pair_t;

	typedef enum logic [1:0] {HIT_NO, HIT_YES, HIT_PREDICT} hit_src_t;

	typedef struct {
		seg_pair_t pair;
		hit_src_t  src;
	} probe_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [8*COORD_BITS-1:0] s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [7:0]              m_tdata;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_req = 1'b0;
	bit sink_held = 1'b0;
	int errors = 0;
	int n_sent = 0;
	int n_touch = 0;
	int n_apart = 0;

	bit        hits_pending[$];
	seg_pair_t pairs_pending[$];
	probe_t    probes[N_PROBES];

	segment_intersection_test #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic seg_pair_t mk(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.a_start_x = coord_t'(ax0);
		p.a_start_y = coord_t'(ay0);
		p.a_end_x   = coord_t'(ax1);
		p.a_end_y   = coord_t'(ay1);
		p.b_start_x = coord_t'(bx0);
		p.b_start_y = coord_t'(by0);
		p.b_end_x   = coord_t'(bx1);
		p.b_end_y   = coord_t'(by1);
		return p;
	endfunction

	// which side of line p->q the point r lies on, products kept exact in 64 bits
	function automatic sit_pkg::orient_t turn_sign(longint px, longint py,
			longint qx, longint qy, longint rx, longint ry);
		longint lhs, rhs;
		lhs = (qx - px) * (ry - py);
		rhs = (rx - px) * (qy - py);
		if (lhs > rhs)
			return sit_pkg::ORI_POS;
		if (lhs < rhs)
			return sit_pkg::ORI_NEG;
		return sit_pkg::ORI_ZERO;
	endfunction

	function automatic sit_pkg::orient_t sign_mul(sit_pkg::orient_t s0,
			sit_pkg::orient_t s1);
		if (s0 == sit_pkg::ORI_ZERO || s1 == sit_pkg::ORI_ZERO)
			return sit_pkg::ORI_ZERO;
		return (s0 == s1) ? sit_pkg::ORI_POS : sit_pkg::ORI_NEG;
	endfunction

	function automatic bit lex_le(longint ax, longint ay, longint bx, longint by);
		if (ax == bx)
			return ay <= by;
		return ax <= bx;
	endfunction

	function automatic bit segments_touch(seg_pair_t p);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, t;
		sit_pkg::orient_t s_ab, s_ba;
		ax0 = $signed(p.a_start_x);
		ay0 = $signed(p.a_start_y);
		ax1 = $signed(p.a_end_x);
		ay1 = $signed(p.a_end_y);
		bx0 = $signed(p.b_start_x);
		by0 = $signed(p.b_start_y);
		bx1 = $signed(p.b_end_x);
		by1 = $signed(p.b_end_y);
		if (bx0 < 0 || by0 < 0 || bx1 < 0 || by1 < 0)
			return 1'b0;
		s_ab = sign_mul(turn_sign(ax0, ay0, ax1, ay1, bx0, by0),
			turn_sign(ax0, ay0, ax1, ay1, bx1, by1));
		s_ba = sign_mul(turn_sign(bx0, by0, bx1, by1, ax0, ay0),
			turn_sign(bx0, by0, bx1, by1, ax1, ay1));
		if (s_ab != sit_pkg::ORI_ZERO || s_ba != sit_pkg::ORI_ZERO)
			return s_ab != sit_pkg::ORI_POS && s_ba != sit_pkg::ORI_POS;
		// collinear or degenerate: order each segment's ends and test the ranges
		if (lex_le(ax1, ay1, ax0, ay0)) begin
			t = ax0; ax0 = ax1; ax1 = t;
			t = ay0; ay0 = ay1; ay1 = t;
		end
		if (lex_le(bx1, by1, bx0, by0)) begin
			t = bx0; bx0 = bx1; bx1 = t;
			t = by0; by0 = by1; by1 = t;
		end
		return lex_le(bx0, by0, ax1, ay1) && lex_le(ax0, ay0, bx1, by1);
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int kind, bx, by, dx, dy, i;
		int k[4];
		int corner_vals[6];
		corner_vals = '{-32768, -1, 0, 1, 32766, 32767};
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			p = {$urandom, $urandom, $urandom, $urandom};
		end else if (kind < 5) begin
			p = {$urandom, $urandom, $urandom, $urandom};
			p.b_start_x = coord_t'($urandom_range(0, 32767));
			p.b_start_y = coord_t'($urandom_range(0, 32767));
			p.b_end_x   = coord_t'($urandom_range(0, 32767));
			p.b_end_y   = coord_t'($urandom_range(0, 32767));
		end else if (kind < 7) begin
			// small grid, lots of touching and shared lines
			p = mk(int'($urandom_range(0, 19)) - 4, int'($urandom_range(0, 19)) - 4,
				int'($urandom_range(0, 19)) - 4, int'($urandom_range(0, 19)) - 4,
				$urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15));
		end else if (kind < 9) begin
			// all four points on one line through (bx, by)
			bx = $urandom_range(0, 2000);
			by = $urandom_range(0, 2000);
			dx = int'($urandom_range(0, 16)) - 8;
			dy = int'($urandom_range(0, 16)) - 8;
			for (i = 0; i < 4; i++)
				k[i] = int'($urandom_range(0, 60)) - 20;
			p = mk(bx + k[0] * dx, by + k[0] * dy, bx + k[1] * dx, by + k[1] * dy,
				bx + k[2] * dx, by + k[2] * dy, bx + k[3] * dx, by + k[3] * dy);
		end else begin
			p = mk(corner_vals[$urandom_range(0, 5)], corner_vals[$urandom_range(0, 5)],
				corner_vals[$urandom_range(0, 5)], corner_vals[$urandom_range(0, 5)],
				corner_vals[$urandom_range(0, 5)], corner_vals[$urandom_range(0, 5)],
				corner_vals[$urandom_range(0, 5)], corner_vals[$urandom_range(0, 5)]);
			if ($urandom_range(0, 1)) begin
				p.b_end_x = p.b_start_x;
				p.b_end_y = p.b_start_y;
			end
		end
		return p;
	endfunction

	task automatic send_pair(seg_pair_t pair, hit_src_t src);
		bit exp_hit;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pair;
		do
			@(posedge clk);
		while (!s_tready);
		exp_hit = (src == HIT_PREDICT) ? segments_touch(pair) : (src == HIT_YES);
		hits_pending  = {hits_pending, exp_hit};
		pairs_pending = {pairs_pending, pair};
		n_sent++;
	endtask

	// result side: check each transaction, then pick the next ready level
	always @(posedge clk) begin : sink
		bit        want;
		seg_pair_t sent;
		if (m_tvalid && m_tready) begin
			if (hits_pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual intersects=%0d",
					$time, m_tdata[0]);
				errors++;
			end else begin
				want = hits_pending.pop_front();
				sent = pairs_pending.pop_front();
				if (m_tdata[0] !== want) begin
					$display("%0t: intersects mismatch, expected %0d, actual %0d",
						$time, want, m_tdata[0]);
					$display("  a=(%0d,%0d)-(%0d,%0d) b=(%0d,%0d)-(%0d,%0d)",
						sent.a_start_x, sent.a_start_y, sent.a_end_x, sent.a_end_y,
						sent.b_start_x, sent.b_start_y, sent.b_end_x, sent.b_end_y);
					errors++;
				end
				if (want)
					n_touch++;
				else
					n_apart++;
			end
		end
		m_tready <= !sink_held && ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// long hold-off on the result side so the pipeline fills and s_tready drops
	initial begin : long_hold
		wait (hold_req);
		@(posedge clk);
		sink_held <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_held <= 1'b0;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, hits_pending.size());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int ph, i;
		probes = '{
			'{mk(0, 0, 0, 0, 0, 0, 0, 0), HIT_YES},
			'{mk(0, 0, 10, 10, -1, 10, 10, 0), HIT_NO},
			'{mk(0, 0, 10, 10, 0, -5, 10, 0), HIT_NO},
			'{mk(0, 0, 10, 10, 0, 10, -32768, 0), HIT_NO},
			'{mk(0, 0, 10, 10, 0, 10, 10, -32768), HIT_NO},
			'{mk(0, 0, 10, 10, 0, 10, 10, 0), HIT_YES},
			'{mk(0, 0, 10, 0, 0, 5, 10, 5), HIT_NO},
			'{mk(0, 0, 10, 0, 5, 0, 20, 0), HIT_YES},
			'{mk(0, 0, 4, 0, 5, 0, 9, 0), HIT_NO},
			'{mk(10, 0, 0, 0, 20, 0, 10, 0), HIT_YES},
			'{mk(0, 0, 5, 5, 5, 5, 10, 0), HIT_YES},
			'{mk(0, 0, 10, 0, 5, 0, 5, 7), HIT_PREDICT},
			'{mk(0, 0, 6, 6, 3, 3, 3, 3), HIT_PREDICT},
			'{mk(0, 0, 6, 6, 3, 4, 3, 4), HIT_PREDICT},
			'{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), HIT_YES},
			'{mk(-32768, -32768, -32768, -32768, 0, 0, 0, 0), HIT_PREDICT},
			'{mk(-32768, -32768, 32767, 32767, 0, 32767, 32767, 0), HIT_PREDICT},
			'{mk(-32768, 32767, 32767, -32768, 32767, 32767, 32767, 32766), HIT_PREDICT},
			'{mk(0, 0, 1, 1, 5, 0, 4, 1), HIT_PREDICT},
			'{mk(3, 0, 3, 10, 3, 10, 3, 20), HIT_YES},
			'{mk(21845, -21846, -21846, 21845, 21845, 21845, 32767, 0), HIT_PREDICT},
			'{mk(3, 0, 3, 5, 3, 6, 3, 9), HIT_PREDICT}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		snk_stall_pct <= 0;
		@(posedge clk);

		for (i = 0; i < N_PROBES; i++)
			send_pair(probes[i].pair, probes[i].src);

		for (ph = 0; ph < 4; ph++) begin
			src_idle_pct  = (ph == 1) ? 80 : (ph == 3) ? 7 : 0;
			snk_stall_pct <= (ph == 2) ? 80 : (ph == 3) ? 7 : 0;
			for (i = 0; i < ITEMS_PER_PHASE; i++)
				send_pair(random_pair(), HIT_PREDICT);
			if (ph == 0) begin
				// keep offering at full rate while the result side is held off
				hold_req = 1'b1;
				for (i = 0; i < BACKLOG_ITEMS; i++)
					send_pair(random_pair(), HIT_PREDICT);
			end
		end
		s_tvalid <= 1'b0;

		while (hits_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d segment pairs (%0d directed): %0d touching, %0d apart",
			n_sent, N_PROBES, n_touch, n_apart);
		$display("idle: none, sender 80%%, receiver 80%%, both 7%%, %0d cycle hold-off",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
